FILE: rtl/htd_pkg.sv
// Shared types and constants for the Huffman token decoder.
// No dependencies; htd_ctrl, htd_dp and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

  localparam int unsigned TREE_NODES_DEF    = 1024;
  localparam int unsigned DICT_BYTES_DEF    = 4096;
  localparam int unsigned MAX_TOKEN_LEN_DEF = 32;

  localparam int unsigned TOKEN_BASE = 128;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned MOD_CNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_WR_TREE = 2'd0,
    ACT_WR_DICT = 2'd1,
    ACT_START   = 2'd2,
    ACT_DECODE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TSEL_CHILD = 2'd0,
    TSEL_LEFT  = 2'd1,
    TSEL_RIGHT = 2'd2
  } tsel_e;

  typedef enum logic [1:0] {
    OSEL_END  = 2'd0,
    OSEL_CHAR = 2'd1,
    OSEL_DICT = 2'd2
  } osel_e;

  typedef struct packed {
    logic    accept;
    logic    tree_re;
    tsel_e   tree_sel;
    logic    take_node;
    logic    mod_load;
    logic    mod_step;
    logic    set_pos;
    logic    clr_pos;
    logic    set_end;
    logic    dict_start;
    logic    dict_adv;
    logic    cur_first;
    logic    cur_adv;
    logic    emit;
    osel_e   out_sel;
  } cmd_t;

  typedef struct packed {
    logic end_seen;
    logic direct_node;
    logic mod_done;
    logic left_nz;
    logic token_zero;
    logic token_char;
    logic byte_zero;
    logic run_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/huffman_token_decoder.sv
// Top level of the Huffman token decoder: joins htd_ctrl and htd_dp.
// Depends on htd_pkg, htd_ctrl, htd_dp and htd_ram.
//
//   channel  dir  data                                        user / last
//   s_axis   in   address, write_value, code_bit              tuser = action
//   m_axis   out  character                                   tuser = eos, trunc; tlast
//
// Write, start and ignored decode beats are taken in S_IDLE alone; a decode bit walks
// S_CHILD and S_LEFT on an inner node, then S_TOKEN on a leaf with a character or end
// token, and S_DFIRST and S_DNEXT per character for a dictionary token, as set by the
// single read port of each RAM. A TREE_NODES that is not a power of two adds S_MOD for
// the child reduction. Reset clears control state only; the RAMs are not cleared. A
// stalled output holds the walk but a full output register still admits beats that
// produce nothing.
`timescale 1ns / 1ps
`default_nettype none

module huffman_token_decoder #(
  parameter int unsigned TREE_NODES    = htd_pkg::TREE_NODES_DEF,
  parameter int unsigned DICT_BYTES    = htd_pkg::DICT_BYTES_DEF,
  parameter int unsigned MAX_TOKEN_LEN = htd_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // address[11:0], write_value[27:12], code_bit[28]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,  // character[7:0]
  output logic      [1:0]  m_axis_tuser,  // end_of_stream[0], truncated[1]
  output logic             m_axis_tlast   // last_of_run
);

  import htd_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  action_e action;
  logic    out_eos, out_trunc;

  assign action = action_e'(s_axis_tuser);

  htd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (action),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htd_dp #(
    .TREE_NODES    (TREE_NODES),
    .DICT_BYTES    (DICT_BYTES),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_eos_o   (out_eos),
    .out_last_o  (m_axis_tlast),
    .out_trunc_o (out_trunc)
  );

  assign m_axis_tuser = {out_trunc, out_eos};

endmodule

`default_nettype wire

FILE: rtl/htd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module htd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/htd_ctrl.sv
// Sequencing state machine for the Huffman token decoder.
// Depends on htd_pkg; drives commands into htd_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module htd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire htd_pkg::action_e action_i,
  input  wire htd_pkg::sts_t    sts_i,
  output htd_pkg::cmd_t         cmd_o
);

  import htd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHILD  = 7'b0000010,
    S_MOD    = 7'b0000100,
    S_LEFT   = 7'b0001000,
    S_TOKEN  = 7'b0010000,
    S_DFIRST = 7'b0100000,
    S_DNEXT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d      = state_q;
    cmd          = '0;
    cmd.tree_sel = TSEL_CHILD;
    cmd.out_sel  = OSEL_END;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          if (action_i == ACT_DECODE && !sts_i.end_seen) begin
            cmd.tree_re  = 1'b1;
            cmd.tree_sel = TSEL_CHILD;
            state_d      = S_CHILD;
          end
        end
      end
      S_CHILD: begin
        if (sts_i.direct_node) begin
          cmd.tree_re   = 1'b1;
          cmd.tree_sel  = TSEL_LEFT;
          cmd.take_node = 1'b1;
          state_d       = S_LEFT;
        end else begin
          cmd.mod_load = 1'b1;
          state_d      = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd.tree_re   = 1'b1;
          cmd.tree_sel  = TSEL_LEFT;
          cmd.take_node = 1'b1;
          state_d       = S_LEFT;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_LEFT: begin
        if (sts_i.left_nz) begin
          cmd.set_pos = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd.tree_re  = 1'b1;
          cmd.tree_sel = TSEL_RIGHT;
          state_d      = S_TOKEN;
        end
      end
      S_TOKEN: begin
        cmd.clr_pos = 1'b1;
        if (sts_i.token_zero) begin
          if (sts_i.out_free) begin
            cmd.emit    = 1'b1;
            cmd.out_sel = OSEL_END;
            cmd.set_end = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (sts_i.token_char) begin
          if (sts_i.out_free) begin
            cmd.emit    = 1'b1;
            cmd.out_sel = OSEL_CHAR;
            state_d     = S_IDLE;
          end
        end else begin
          cmd.dict_start = 1'b1;
          state_d        = S_DFIRST;
        end
      end
      S_DFIRST: begin
        if (sts_i.byte_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd.cur_first = 1'b1;
          cmd.dict_adv  = 1'b1;
          state_d       = S_DNEXT;
        end
      end
      S_DNEXT: begin
        if (sts_i.out_free) begin
          cmd.emit    = 1'b1;
          cmd.out_sel = OSEL_DICT;
          if (sts_i.run_last || sts_i.byte_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd.cur_adv  = 1'b1;
            cmd.dict_adv = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

`ifndef SYNTH
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.set_end |-> cmd.emit && cmd.out_sel == OSEL_END)
    else $error("end flag set without an end beat");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts_i.out_free)
    else $error("beat issued into a full output register");

  a_inner_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEFT && sts_i.left_nz) |=> state_q == S_IDLE)
    else $error("inner node did not finish the bit");
`endif

endmodule

`default_nettype wire

FILE: rtl/htd_dp.sv
// Datapath: tree and dictionary RAMs, tree position, child reduction,
// dictionary walk and output register. Depends on htd_pkg and htd_ram.
`timescale 1ns / 1ps
`default_nettype none

module htd_dp #(
  parameter int unsigned TREE_NODES    = htd_pkg::TREE_NODES_DEF,
  parameter int unsigned DICT_BYTES    = htd_pkg::DICT_BYTES_DEF,
  parameter int unsigned MAX_TOKEN_LEN = htd_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire htd_pkg::cmd_t                    cmd_i,
  output htd_pkg::sts_t                         sts_o,
  input  wire htd_pkg::action_e                 action_i,
  input  wire logic [htd_pkg::IN_DATA_W-1:0]    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [htd_pkg::CHAR_W-1:0]       out_char_o,
  output logic                                  out_eos_o,
  output logic                                  out_last_o,
  output logic                                  out_trunc_o
);

  import htd_pkg::*;

  localparam int unsigned PW        = $clog2(TREE_NODES);
  localparam int unsigned TDEPTH    = 2 * TREE_NODES;
  localparam int unsigned TAW       = PW + 1;
  localparam int unsigned DAW       = (DICT_BYTES > 1) ? $clog2(DICT_BYTES) : 1;
  localparam int unsigned NW        = $clog2(MAX_TOKEN_LEN + 1);
  localparam bit          POW2      = (TREE_NODES & (TREE_NODES - 1)) == 0;
  localparam int unsigned MOD_STEPS = POW2 ? 0 : 2;
  localparam logic [15:0] RECIP     = 16'(32'h10000 / TREE_NODES);

  logic [ADDR_W-1:0]  in_addr;
  logic [VALUE_W-1:0] in_value;
  logic               in_bit;
  logic [31:0]        waddr_ext;

  assign in_addr   = in_data_i[ADDR_W-1:0];
  assign in_value  = in_data_i[ADDR_W+VALUE_W-1:ADDR_W];
  assign in_bit    = in_data_i[ADDR_W+VALUE_W];
  assign waddr_ext = 32'(in_addr);

  logic               tree_we, dict_we;
  logic [TAW-1:0]     tree_raddr;
  logic [VALUE_W-1:0] tree_rdata;
  logic [7:0]         dict_rdata;
  logic [16:0]        dict_raddr;
  logic               dict_re;

  assign tree_we = cmd_i.accept && action_i == ACT_WR_TREE && waddr_ext < 32'(TDEPTH);
  assign dict_we = cmd_i.accept && action_i == ACT_WR_DICT && waddr_ext < 32'(DICT_BYTES);

  logic [PW-1:0]      pos_q, node_q, node_w;
  logic               end_q;
  logic [VALUE_W-1:0] val_q, quot_q;
  logic [16:0]        rem_q, rem_fix;
  logic [31:0]        quot_prod, back_prod;
  logic [MOD_CNT_W-1:0] cnt_q;

  assign quot_prod = 32'(val_q) * 32'(RECIP);
  assign back_prod = 32'(quot_q) * 32'(TREE_NODES);
  assign rem_fix   = (rem_q >= 17'(TREE_NODES)) ? rem_q - 17'(TREE_NODES) : rem_q;
  assign node_w    = POW2 ? tree_rdata[PW-1:0] : rem_fix[PW-1:0];

  always_comb begin
    case (cmd_i.tree_sel)
      TSEL_CHILD: tree_raddr = {pos_q, in_bit};
      TSEL_LEFT:  tree_raddr = {node_w, 1'b0};
      TSEL_RIGHT: tree_raddr = {node_q, 1'b1};
      default:    tree_raddr = {node_q, 1'b1};
    endcase
  end

  htd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TDEPTH)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (waddr_ext[TAW-1:0]),
    .wdata_i (in_value),
    .re_i    (cmd_i.tree_re),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  logic [16:0] tok_off;
  logic [16:0] dptr_q;
  logic        dinr_q;
  logic [7:0]  byte_w, cur_q;
  logic [NW-1:0] n_q;

  assign tok_off    = {1'b0, tree_rdata} - 17'(TOKEN_BASE);
  assign dict_raddr = cmd_i.dict_start ? tok_off : dptr_q;
  assign dict_re    = cmd_i.dict_start || cmd_i.dict_adv;
  assign byte_w     = dinr_q ? dict_rdata : 8'd0;

  htd_ram #(
    .WIDTH (8),
    .DEPTH (DICT_BYTES)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (waddr_ext[DAW-1:0]),
    .wdata_i (in_value[7:0]),
    .re_i    (dict_re),
    .raddr_i (dict_raddr[DAW-1:0]),
    .rdata_o (dict_rdata)
  );

  // tree position, end flag and child reduction counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      end_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.accept && action_i == ACT_START) begin
        pos_q <= '0;
        end_q <= 1'b0;
      end
      if (cmd_i.set_pos) begin
        pos_q <= node_q;
      end
      if (cmd_i.clr_pos) begin
        pos_q <= '0;
      end
      if (cmd_i.set_end) begin
        end_q <= 1'b1;
      end
      if (cmd_i.mod_load) begin
        cnt_q <= MOD_CNT_W'(MOD_STEPS);
      end else if (cmd_i.mod_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // reduce the child value: estimate the quotient by reciprocal multiply,
  // form the remainder, then correct it by one compare and subtract
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_load) begin
      val_q <= tree_rdata;
    end else if (cmd_i.mod_step) begin
      quot_q <= quot_prod[31:16];
      rem_q  <= 17'(32'(val_q) - back_prod);
    end
    if (cmd_i.take_node) begin
      node_q <= node_w;
    end
    if (dict_re) begin
      dptr_q <= dict_raddr + 17'd1;
      dinr_q <= dict_raddr < 17'(DICT_BYTES);
    end
    if (cmd_i.cur_first) begin
      cur_q <= byte_w;
      n_q   <= '0;
    end else if (cmd_i.cur_adv) begin
      cur_q <= byte_w;
      n_q   <= n_q + 1'b1;
    end
  end

  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_eos_q, out_last_q, out_trunc_q;
  logic       run_last;

  assign run_last = n_q == NW'(MAX_TOKEN_LEN - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.out_sel)
        OSEL_END: begin
          out_char_q  <= 8'd0;
          out_eos_q   <= 1'b1;
          out_last_q  <= 1'b1;
          out_trunc_q <= 1'b0;
        end
        OSEL_CHAR: begin
          out_char_q  <= tree_rdata[7:0];
          out_eos_q   <= 1'b0;
          out_last_q  <= 1'b1;
          out_trunc_q <= 1'b0;
        end
        OSEL_DICT: begin
          out_char_q  <= cur_q;
          out_eos_q   <= 1'b0;
          out_last_q  <= run_last || byte_w == 8'd0;
          out_trunc_q <= run_last && byte_w != 8'd0;
        end
        default: begin
          out_char_q  <= 8'd0;
          out_eos_q   <= 1'b0;
          out_last_q  <= 1'b1;
          out_trunc_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_eos_o   = out_eos_q;
  assign out_last_o  = out_last_q;
  assign out_trunc_o = out_trunc_q;

  assign sts_o.end_seen    = end_q;
  assign sts_o.direct_node = POW2;
  assign sts_o.mod_done    = cnt_q == '0;
  assign sts_o.left_nz     = tree_rdata != '0;
  assign sts_o.token_zero  = tree_rdata == '0;
  assign sts_o.token_char  = tree_rdata < VALUE_W'(TOKEN_BASE);
  assign sts_o.byte_zero   = byte_w == 8'd0;
  assign sts_o.run_last    = run_last;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

`ifndef SYNTH
  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(end_q) |-> out_valid_q && out_eos_q)
    else $error("end flag raised without an end beat");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_trunc_q) |-> out_last_q)
    else $error("truncated beat is not the last of its run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_char_q)))
    else $error("stalled output beat changed");
`endif

endmodule

`default_nettype wire
